// File: rtl/kdpq_pkg.sv
// ----------------------------------------------------------------------------
// kdpq_pkg
// Shared types and constants for the keyframe-aware packet drop queue.
// ----------------------------------------------------------------------------
package kdpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int KIND_W = 3;
    localparam int TYPE_W = 2;
    localparam int MAXV_W = 6;

    // configuration register indexes
    localparam logic CFG_ENABLE    = 1'b0;
    localparam logic CFG_MAX_VIDEO = 1'b1;

    // request operations
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [TYPE_W-1:0] TYPE_VIDEO = 2'd0;

    typedef enum logic [KIND_W-1:0] {
        KIND_POPPED   = 3'd0,
        KIND_DROPPED  = 3'd1,
        KIND_ACCEPTED = 3'd2,
        KIND_REJECTED = 3'd3,
        KIND_EMPTY    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_WALK_WAIT,
        ST_FINISH,
        ST_REPLY
    } state_t;

endpackage

// File: rtl/kdpq_store.sv
// ----------------------------------------------------------------------------
// kdpq_store
// Descriptor memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kdpq_store
    import kdpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ENTRY_W     = HANDLE_BITS_DEF + TYPE_W + 1,
    localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [PTR_W-1:0]   wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [PTR_W-1:0]   rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/kdpq_ctrl.sv
// ----------------------------------------------------------------------------
// kdpq_ctrl
// Queue sequencer: pointers, counts, head drop walk and result register.
// ----------------------------------------------------------------------------
module kdpq_ctrl
    import kdpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int PTR_W      = $clog2(QUEUE_DEPTH),
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
    localparam int ENTRY_W    = HANDLE_BITS + TYPE_W + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_enable,
    input  logic [MAXV_W-1:0]      cfg_max_video,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic [HANDLE_BITS-1:0] s_handle,
    input  logic [TYPE_W-1:0]      s_type,
    input  logic                   s_key,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_kind,
    output logic [HANDLE_BITS-1:0] m_handle,
    output logic [TYPE_W-1:0]      m_type,
    output logic                   m_key,
    output logic                   m_last
);

    state_t state_reg, state_next;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] video_reg, video_next;
    logic             seen_key_reg, seen_key_next;
    kind_t            reply_reg, reply_next;

    logic [HANDLE_BITS-1:0] handle_reg;
    logic [TYPE_W-1:0]      type_reg;
    logic                   key_reg;

    logic                   m_valid_reg, m_valid_next;
    kind_t                  m_kind_reg, m_kind_next;
    logic [HANDLE_BITS-1:0] m_handle_reg, m_handle_next;
    logic [TYPE_W-1:0]      m_type_reg, m_type_next;
    logic                   m_key_reg, m_key_next;
    logic                   m_last_reg, m_last_next;

    logic               wr_en;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic [HANDLE_BITS-1:0] hd_handle;
    logic [TYPE_W-1:0]      hd_type;
    logic                   hd_key;
    logic                   hd_video_key;
    logic                   out_free;
    logic                   accept;
    logic [PTR_W-1:0]       head_adv;
    logic [PTR_W-1:0]       tail_adv;
    logic [CNT_W-1:0]       video_dec;

    assign hd_handle    = rd_data[HANDLE_BITS-1:0];
    assign hd_type      = rd_data[HANDLE_BITS +: TYPE_W];
    assign hd_key       = rd_data[ENTRY_W-1];
    assign hd_video_key = (hd_type == TYPE_VIDEO) && hd_key;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;

    assign head_adv = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_adv = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign video_dec = ((hd_type == TYPE_VIDEO) && (video_reg != '0)) ?
                       video_reg - 1'b1 : video_reg;

    // Reads and the single write never share a cycle, so the FSM order alone
    // keeps a write to the tail visible to a later read of the same entry.
    kdpq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_W     (ENTRY_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data ({key_reg, type_reg, handle_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            video_reg    <= '0;
            seen_key_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            video_reg    <= video_next;
            seen_key_reg <= seen_key_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        reply_reg    <= reply_next;
        m_kind_reg   <= m_kind_next;
        m_handle_reg <= m_handle_next;
        m_type_reg   <= m_type_next;
        m_key_reg    <= m_key_next;
        m_last_reg   <= m_last_next;
        if (accept) begin
            handle_reg <= s_handle;
            type_reg   <= s_type;
            key_reg    <= s_key;
        end
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        video_next    = video_reg;
        seen_key_next = seen_key_reg;
        reply_next    = reply_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = head_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_handle_next = m_handle_reg;
        m_type_next   = m_type_reg;
        m_key_next    = m_key_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    seen_key_next = 1'b0;
                    if (s_op == OP_POP) begin
                        if (count_reg == '0) begin
                            reply_next = KIND_EMPTY;
                            state_next = ST_REPLY;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = ST_POP_WAIT;
                        end
                    end else if (!cfg_enable) begin
                        reply_next = KIND_REJECTED;
                        state_next = ST_REPLY;
                    end else if ((MAXV_W'(video_reg) > cfg_max_video) &&
                                 (count_reg != '0)) begin
                        rd_en      = 1'b1;
                        state_next = ST_WALK_WAIT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_POP_WAIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_POPPED;
                    m_handle_next = hd_handle;
                    m_type_next   = hd_type;
                    m_key_next    = hd_key;
                    m_last_next   = 1'b1;
                    head_next     = head_adv;
                    count_next    = count_reg - 1'b1;
                    video_next    = video_dec;
                    state_next    = ST_IDLE;
                end
            end

            ST_WALK_WAIT: begin
                if (seen_key_reg && hd_video_key) begin
                    // second video keyframe: keep it at the head
                    state_next = ST_FINISH;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_DROPPED;
                    m_handle_next = hd_handle;
                    m_type_next   = hd_type;
                    m_key_next    = hd_key;
                    m_last_next   = 1'b0;
                    head_next     = head_adv;
                    count_next    = count_reg - 1'b1;
                    video_next    = video_dec;
                    seen_key_next = seen_key_reg || hd_video_key;
                    if (count_reg != CNT_W'(1)) begin
                        // fetch the next head while this drop goes out
                        rd_en   = 1'b1;
                        rd_addr = head_adv;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_handle_next = '0;
                    m_type_next   = '0;
                    m_key_next    = 1'b0;
                    m_last_next   = 1'b1;
                    if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        m_kind_next = KIND_REJECTED;
                    end else begin
                        m_kind_next = KIND_ACCEPTED;
                        wr_en       = 1'b1;
                        tail_next   = tail_adv;
                        count_next  = count_reg + 1'b1;
                        if (type_reg == TYPE_VIDEO) begin
                            video_next = video_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_REPLY: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = reply_reg;
                    m_handle_next = '0;
                    m_type_next   = '0;
                    m_key_next    = 1'b0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_kind   = m_kind_reg;
    assign m_handle = m_handle_reg;
    assign m_type   = m_type_reg;
    assign m_key    = m_key_reg;
    assign m_last   = m_last_reg;

endmodule

// File: rtl/keyframe_drop_packet_queue_unit.sv
// ----------------------------------------------------------------------------
// keyframe_drop_packet_queue_unit
// Packet descriptor queue that drops from the head up to the second video
// keyframe once too many video packets are queued.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser selects push or pop, s_tdata
//   carries the descriptor of a pushed packet. Results leave on the m_ stream:
//   m_tuser is the result kind, m_tdata the popped or dropped descriptor, and
//   m_tlast marks the final result of a request.
//   cfg_we writes enable (index 0) or max_video_packets (index 1); write only
//   while no request is in flight.
//   Timing: one request at a time. A pop reaches the output register from
//   ST_POP_WAIT and a reply without data (empty, disabled) from ST_REPLY;
//   a push drops each entry from ST_WALK_WAIT, stops there at a kept
//   keyframe, then places its result from ST_FINISH. The drop walk is
//   paced by the registered read of the descriptor memory, with the next
//   head fetched while each drop is sent.
//   Reset clears pointers, counts and configuration; memory contents are
//   not cleared and need no clearing pass. When m_tready is low the result
//   register holds while it has a result and the walk pauses; s_tready is
//   low until the request has placed its final result.
// ----------------------------------------------------------------------------
module keyframe_drop_packet_queue_unit
    import kdpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int DATA_W     = ((HANDLE_BITS + TYPE_W + 1 + 7) / 8) * 8,
    localparam int PAD_W      = DATA_W - HANDLE_BITS - TYPE_W - 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [MAXV_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // packet_handle, packet_type, is_keyframe
    input  logic [0:0]        s_tuser,   // operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // out_handle, out_type, out_keyframe
    output logic [KIND_W-1:0] m_tuser,   // result_kind
    output logic              m_tlast
);

    logic              enable_reg;
    logic [MAXV_W-1:0] max_video_reg;

    logic [HANDLE_BITS-1:0] m_handle;
    logic [TYPE_W-1:0]      m_type;
    logic                   m_key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            max_video_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLE:    enable_reg    <= cfg_wdata[0];
                CFG_MAX_VIDEO: max_video_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    kdpq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_enable    (enable_reg),
        .cfg_max_video (max_video_reg),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .s_op          (s_tuser[0]),
        .s_handle      (s_tdata[HANDLE_BITS-1:0]),
        .s_type        (s_tdata[HANDLE_BITS +: TYPE_W]),
        .s_key         (s_tdata[HANDLE_BITS+TYPE_W]),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_kind        (m_tuser),
        .m_handle      (m_handle),
        .m_type        (m_type),
        .m_key         (m_key),
        .m_last        (m_tlast)
    );

    generate
        if (PAD_W > 0) begin : g_pad
            assign m_tdata = {{PAD_W{1'b0}}, m_key, m_type, m_handle};
        end else begin : g_nopad
            assign m_tdata = {m_key, m_type, m_handle};
        end
    endgenerate

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyframe-aware packet drop queue. Push and pop
// requests go in on the s_ stream. A shadow copy of the queue predicts every
// result: pops, empty replies, rejects, and the head drops up to the second
// video keyframe. Each result on the m_ stream is checked in order against
// that prediction, or for a directed row against the result in its plan entry.
// ----------------------------------------------------------------------------
module tb;
    import kdpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int HB          = HANDLE_BITS_DEF;
    localparam int DATA_W      = ((HB + TYPE_W + 1 + 7) / 8) * 8;
    localparam int PAD_W       = DATA_W - HB - TYPE_W - 1;
    localparam int KEEP_AT_KEY = 2;
    localparam int SETTLE      = 8;
    localparam int STALL_LIMIT = 3000;
    localparam int PEND_DEPTH  = 128;
    localparam int PLAN_DEPTH  = 40;

    localparam logic [TYPE_W-1:0] TYPE_AUDIO    = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_SUBTITLE = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_OTHER    = 2'd3;

    typedef struct packed {
        logic [HB-1:0]     handle;
        logic [TYPE_W-1:0] ptype;
        logic              key;
    } desc_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PAD_W-1:0]  pad;
        logic              key;
        logic [TYPE_W-1:0] ptype;
        logic [HB-1:0]     handle;
        logic              last;
    } result_t;

    typedef struct {
        bit                is_cfg;
        logic [0:0]        idx;
        logic [MAXV_W-1:0] val;
        logic              op;
        logic [HB-1:0]     h;
        logic [TYPE_W-1:0] t;
        logic              k;
        bit                chk;
        result_t           want;
    } row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [0:0]        cfg_index;
    logic [MAXV_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic              m_tlast;

    keyframe_drop_packet_queue_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // shadow of the queue and its configuration
    desc_t             shadow_mem[DEPTH];
    int                shadow_head;
    int                shadow_cnt;
    int                shadow_video_cnt;
    logic              shadow_en;
    logic [MAXV_W-1:0] shadow_max;

    // expected results in order; written by the sender, read by the monitor
    result_t pend_mem[PEND_DEPTH];
    int      pend_wr;
    int      pend_rd;

    result_t step_mem[DEPTH+1];
    int      step_cnt;
    row_t    plan_mem[PLAN_DEPTH];
    int      plan_cnt;

    int      send_idle_pct;
    int      recv_idle_pct;
    int      gop_left;
    int      errors;
    int      n_req;
    int      n_res;
    int      n_drop;
    int      n_reject;
    int      n_empty;
    int      idle_cycles;
    result_t got;
    result_t want;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic result_t mk_res(kind_t kind, logic [HB-1:0] h, logic [TYPE_W-1:0] t,
                                       logic k, logic last);
        result_t r;
        r.kind   = kind;
        r.pad    = '0;
        r.key    = k;
        r.ptype  = t;
        r.handle = h;
        r.last   = last;
        return r;
    endfunction

    function automatic row_t req_row(logic op, logic [HB-1:0] h, logic [TYPE_W-1:0] t,
                                     logic k);
        row_t r;
        r.is_cfg = 1'b0;
        r.idx    = CFG_ENABLE;
        r.val    = '0;
        r.op     = op;
        r.h      = h;
        r.t      = t;
        r.k      = k;
        r.chk    = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic row_t req_exp(logic op, logic [HB-1:0] h, logic [TYPE_W-1:0] t,
                                     logic k, result_t w);
        row_t r;
        r      = req_row(op, h, t, k);
        r.chk  = 1'b1;
        r.want = w;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [0:0] idx, logic [MAXV_W-1:0] val);
        row_t r;
        r        = req_row(OP_POP, '0, '0, 1'b0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic void plan_add(row_t r);
        plan_mem[plan_cnt] = r;
        plan_cnt++;
    endfunction

    function automatic void step_add(result_t r);
        step_mem[step_cnt] = r;
        step_cnt++;
    endfunction

    function automatic void expect_add(result_t r);
        pend_mem[pend_wr % PEND_DEPTH] = r;
        pend_wr++;
    endfunction

    function automatic void shadow_append(desc_t d);
        shadow_mem[(shadow_head + shadow_cnt) % DEPTH] = d;
        shadow_cnt++;
    endfunction

    function automatic void take_head();
        if (shadow_mem[shadow_head].ptype == TYPE_VIDEO && shadow_video_cnt > 0)
            shadow_video_cnt--;
        shadow_head = (shadow_head + 1) % DEPTH;
        shadow_cnt--;
    endfunction

    // compute the results one request causes and advance the shadow queue
    function automatic void predict_queue_results(row_t r);
        desc_t d;
        int    keys;
        step_cnt = 0;
        if (r.op == OP_POP) begin
            if (shadow_cnt == 0) begin
                step_add(mk_res(KIND_EMPTY, '0, '0, 1'b0, 1'b1));
            end else begin
                d = shadow_mem[shadow_head];
                step_add(mk_res(KIND_POPPED, d.handle, d.ptype, d.key, 1'b1));
                take_head();
            end
        end else if (!shadow_en) begin
            step_add(mk_res(KIND_REJECTED, '0, '0, 1'b0, 1'b1));
        end else begin
            if (shadow_video_cnt > int'(shadow_max)) begin
                keys = 0;
                while (shadow_cnt > 0) begin
                    d = shadow_mem[shadow_head];
                    if (d.ptype == TYPE_VIDEO && d.key)
                        keys++;
                    // keep the second video keyframe at the head
                    if (keys >= KEEP_AT_KEY)
                        break;
                    step_add(mk_res(KIND_DROPPED, d.handle, d.ptype, d.key, 1'b0));
                    take_head();
                end
            end
            if (shadow_cnt >= DEPTH) begin
                step_add(mk_res(KIND_REJECTED, '0, '0, 1'b0, 1'b1));
            end else begin
                d.handle = r.h;
                d.ptype  = r.t;
                d.key    = r.k;
                shadow_append(d);
                if (r.t == TYPE_VIDEO)
                    shadow_video_cnt++;
                step_add(mk_res(KIND_ACCEPTED, '0, '0, 1'b0, 1'b1));
            end
        end
    endfunction

    task automatic send_req(row_t r);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {{PAD_W{1'b0}}, r.k, r.t, r.h};
        do
            @(posedge aclk);
        while (!s_tready);
        n_req++;
        predict_queue_results(r);
        if (r.chk) begin
            expect_add(r.want);
        end else begin
            for (int i = 0; i < step_cnt; i++)
                expect_add(step_mem[i]);
        end
    endtask

    // hold off the sender until every expected result is out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pend_wr != pend_rd)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [MAXV_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_ENABLE)
            shadow_en = val[0];
        else
            shadow_max = val;
    endtask

    task automatic set_reg(logic [0:0] idx, logic [MAXV_W-1:0] val);
        drain_results();
        write_reg(idx, val);
    endtask

    // mostly GOP-shaped traffic, some noise, occasional full drain
    task automatic random_items(int count, int pop_pct);
        row_t              r;
        logic [TYPE_W-1:0] t;
        logic              k;
        int                pick;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < pop_pct) begin
                r = req_row(OP_POP, HB'($urandom), TYPE_W'($urandom), 1'($urandom));
            end else begin
                if ($urandom_range(0, 99) < 85) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60) begin
                        t = TYPE_VIDEO;
                        k = (gop_left == 0);
                        if (gop_left == 0)
                            gop_left = $urandom_range(2, 8);
                        gop_left--;
                    end else begin
                        t = (pick < 90) ? TYPE_AUDIO : TYPE_SUBTITLE;
                        k = 1'($urandom);
                    end
                end else begin
                    t = TYPE_W'($urandom_range(0, 3));
                    k = 1'($urandom);
                end
                r = req_row(OP_PUSH, HB'($urandom), t, k);
            end
            send_req(r);
            if ($urandom_range(0, 99) < 3)
                drain_results();
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = m_tuser;
            got.pad    = m_tdata[DATA_W-1 -: PAD_W];
            got.key    = m_tdata[HB+TYPE_W];
            got.ptype  = m_tdata[HB +: TYPE_W];
            got.handle = m_tdata[HB-1:0];
            got.last   = m_tlast;
            n_res++;
            case (got.kind)
                KIND_DROPPED:  n_drop++;
                KIND_REJECTED: n_reject++;
                KIND_EMPTY:    n_empty++;
                default: ;
            endcase
            if (pend_wr == pend_rd) begin
                $display("%0t ERROR: unexpected result kind=%0d handle=%h",
                         $time, got.kind, got.handle);
                $display("%0t        type=%0d key=%0d last=%0d",
                         $time, got.ptype, got.key, got.last);
                errors++;
            end else begin
                want = pend_mem[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (got !== want) begin
                    $display("%0t ERROR: expected kind=%0d handle=%h type=%0d key=%0d %s",
                             $time, want.kind, want.handle, want.ptype, want.key,
                             $sformatf("pad=%h last=%0d", want.pad, want.last));
                    $display("%0t        actual   kind=%0d handle=%h type=%0d key=%0d %s",
                             $time, got.kind, got.handle, got.ptype, got.key,
                             $sformatf("pad=%h last=%0d", got.pad, got.last));
                    errors++;
                end
            end
        end
    end

    // end the run when no request moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t ERROR: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        aresetn          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = OP_PUSH;
        shadow_head      = 0;
        shadow_cnt       = 0;
        shadow_video_cnt = 0;
        shadow_en        = 1'b0;
        shadow_max       = '0;
        pend_wr          = 0;
        step_cnt         = 0;
        plan_cnt         = 0;
        gop_left         = 0;
        n_req            = 0;
        send_idle_pct    = 19;
        recv_idle_pct    = 53;

        // reset state: empty queue, pushes refused
        plan_add(req_exp(OP_POP, 16'h0000, TYPE_VIDEO, 1'b0,
                         mk_res(KIND_EMPTY, '0, '0, 1'b0, 1'b1)));
        plan_add(req_exp(OP_PUSH, 16'hffff, TYPE_VIDEO, 1'b1,
                         mk_res(KIND_REJECTED, '0, '0, 1'b0, 1'b1)));
        plan_add(cfg_row(CFG_ENABLE, 6'd1));
        plan_add(cfg_row(CFG_MAX_VIDEO, 6'd32));
        plan_add(req_exp(OP_PUSH, 16'hffff, TYPE_VIDEO, 1'b1,
                         mk_res(KIND_ACCEPTED, '0, '0, 1'b0, 1'b1)));
        plan_add(req_exp(OP_PUSH, 16'h0000, TYPE_AUDIO, 1'b0,
                         mk_res(KIND_ACCEPTED, '0, '0, 1'b0, 1'b1)));
        plan_add(req_exp(OP_PUSH, 16'h8000, TYPE_OTHER, 1'b1,
                         mk_res(KIND_ACCEPTED, '0, '0, 1'b0, 1'b1)));
        plan_add(req_exp(OP_PUSH, 16'h5a5a, TYPE_SUBTITLE, 1'b0,
                         mk_res(KIND_ACCEPTED, '0, '0, 1'b0, 1'b1)));
        plan_add(req_exp(OP_POP, 16'h1234, TYPE_AUDIO, 1'b1,
                         mk_res(KIND_POPPED, 16'hffff, TYPE_VIDEO, 1'b1, 1'b1)));
        plan_add(req_row(OP_POP, 16'h0000, TYPE_VIDEO, 1'b0));
        // type code 3 comes back unchanged
        plan_add(req_exp(OP_POP, 16'hffff, TYPE_OTHER, 1'b1,
                         mk_res(KIND_POPPED, 16'h8000, TYPE_OTHER, 1'b1, 1'b1)));
        plan_add(req_row(OP_POP, 16'h0000, TYPE_VIDEO, 1'b0));
        plan_add(req_exp(OP_POP, 16'h0000, TYPE_VIDEO, 1'b0,
                         mk_res(KIND_EMPTY, '0, '0, 1'b0, 1'b1)));
        // drop walk that stops at the second keyframe
        plan_add(cfg_row(CFG_MAX_VIDEO, 6'd2));
        plan_add(req_row(OP_PUSH, 16'h0010, TYPE_VIDEO, 1'b1));
        plan_add(req_row(OP_PUSH, 16'h0011, TYPE_VIDEO, 1'b0));
        plan_add(req_row(OP_PUSH, 16'h0012, TYPE_AUDIO, 1'b1));
        plan_add(req_row(OP_PUSH, 16'h0013, TYPE_VIDEO, 1'b1));
        plan_add(req_row(OP_PUSH, 16'h0014, TYPE_AUDIO, 1'b0));
        // limit of zero, walk without a second keyframe empties the queue
        plan_add(cfg_row(CFG_MAX_VIDEO, 6'd0));
        plan_add(req_row(OP_PUSH, 16'h0015, TYPE_SUBTITLE, 1'b1));
        plan_add(req_row(OP_PUSH, 16'h0016, TYPE_VIDEO, 1'b0));
        plan_add(req_row(OP_PUSH, 16'h0017, TYPE_VIDEO, 1'b1));
        plan_add(req_row(OP_POP, 16'haaaa, TYPE_OTHER, 1'b1));
        plan_add(cfg_row(CFG_MAX_VIDEO, 6'd63));
        plan_add(req_row(OP_PUSH, 16'h0018, TYPE_VIDEO, 1'b1));
        plan_add(req_row(OP_POP, 16'h5555, TYPE_SUBTITLE, 1'b0));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < plan_cnt; i++) begin
            if (plan_mem[i].is_cfg)
                set_reg(plan_mem[i].idx, plan_mem[i].val);
            else
                send_req(plan_mem[i]);
        end

        set_reg(CFG_MAX_VIDEO, 6'd3);
        random_items(60, 30);
        set_reg(CFG_MAX_VIDEO, 6'd0);
        random_items(30, 30);

        send_idle_pct = 53;
        recv_idle_pct = 19;
        // fill past the storage depth to hit the full-queue reject
        set_reg(CFG_MAX_VIDEO, 6'd32);
        random_items(36, 0);
        random_items(30, 60);
        set_reg(CFG_MAX_VIDEO, 6'd63);
        random_items(20, 30);
        set_reg(CFG_ENABLE, MAXV_W'($urandom_range(0, 31) << 1));
        random_items(15, 40);
        set_reg(CFG_ENABLE, MAXV_W'(($urandom_range(0, 31) << 1) | 1));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_reg(CFG_MAX_VIDEO, MAXV_W'($urandom_range(1, 6)));
        random_items(60, 30);

        drain_results();
        repeat (20) @(negedge aclk);

        $display("tb: %0d requests, %0d results checked: %0d drops, %0d rejects,",
                 n_req, n_res, n_drop, n_reject);
        $display("tb: %0d empty pops; limits 0..63, disabled and full queue covered, %0d %s",
                 n_empty, errors, "mismatches");
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/kdpq_pkg.sv
rtl/kdpq_store.sv
rtl/kdpq_ctrl.sv
rtl/keyframe_drop_packet_queue_unit.sv
bench/tb.sv
